/* src/chev_pkg.sv */
package chev_pkg;

   // Hermite terms, in the order the values arrive on the input
   localparam int TERM_COUNT = 4;
   localparam int START_POINT_IDX = 0;
   localparam int END_POINT_IDX = 1;
   localparam int START_TANGENT_IDX = 2;
   localparam int END_TANGENT_IDX = 3;

   // two weighted sums per item
   localparam int SUM_COUNT = 2;
   localparam int POSITION_SEL = 0;
   localparam int SLOPE_SEL = 1;

endpackage

/* src/chev_basis.sv */
module chev_basis #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [FRAC_BITS:0] in_param,
   input  logic [chev_pkg::TERM_COUNT-1:0][COORD_WIDTH-1:0] in_value,
   output logic out_valid,
   input  logic out_ready,
   output logic [chev_pkg::SUM_COUNT-1:0][chev_pkg::TERM_COUNT-1:0][FRAC_BITS+3:0] out_weight,
   output logic [chev_pkg::TERM_COUNT-1:0][COORD_WIDTH-1:0] out_value
);
   import chev_pkg::*;

   localparam int PW = FRAC_BITS + 1;
   localparam int WW = FRAC_BITS + 4;
   localparam int SQW = 2 * PW;
   localparam int STAGES = 4;
   localparam logic [PW-1:0] UNIT = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [SQW-1:0] HALF = SQW'(1) << (FRAC_BITS - 1);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] ready;

   // stage 1: clamp parameter
   logic [PW-1:0] p1_ff, p1_in;
   logic [TERM_COUNT-1:0][COORD_WIDTH-1:0] v1_ff;
   // stage 2: t^2
   logic [PW-1:0] p2_ff, t2_2_ff, t2_2_in;
   logic [TERM_COUNT-1:0][COORD_WIDTH-1:0] v2_ff;
   logic [SQW-1:0] sq;
   // stage 3: t^3
   logic [PW-1:0] p3_ff, t2_3_ff, t3_3_ff, t3_3_in;
   logic [TERM_COUNT-1:0][COORD_WIDTH-1:0] v3_ff;
   logic [SQW-1:0] cu;
   // stage 4: basis weights and derivatives
   logic [SUM_COUNT-1:0][TERM_COUNT-1:0][WW-1:0] w4_ff, w4_in;
   logic [TERM_COUNT-1:0][COORD_WIDTH-1:0] v4_ff;
   logic signed [WW-1:0] ps, t2s, t3s, us;

   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign in_ready = ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_weight = w4_ff;
   assign out_value = v4_ff;

   always_comb begin
      p1_in = (in_param > UNIT) ? UNIT : in_param;
      sq = p1_ff * p1_ff;
      t2_2_in = PW'((sq + HALF) >> FRAC_BITS);
      cu = t2_2_ff * p2_ff;
      t3_3_in = PW'((cu + HALF) >> FRAC_BITS);

      ps = $signed(WW'(p3_ff));
      t2s = $signed(WW'(t2_3_ff));
      t3s = $signed(WW'(t3_3_ff));
      us = $signed(WW'(UNIT));

      w4_in[POSITION_SEL][START_POINT_IDX] = WW'(2 * t3s - 3 * t2s + us);
      w4_in[POSITION_SEL][END_POINT_IDX] = WW'(3 * t2s - 2 * t3s);
      w4_in[POSITION_SEL][START_TANGENT_IDX] = WW'(t3s - 2 * t2s + ps);
      w4_in[POSITION_SEL][END_TANGENT_IDX] = WW'(t3s - t2s);
      w4_in[SLOPE_SEL][START_POINT_IDX] = WW'(6 * t2s - 6 * ps);
      w4_in[SLOPE_SEL][END_POINT_IDX] = WW'(6 * ps - 6 * t2s);
      w4_in[SLOPE_SEL][START_TANGENT_IDX] = WW'(3 * t2s - 4 * ps + us);
      w4_in[SLOPE_SEL][END_TANGENT_IDX] = WW'(3 * t2s - 2 * ps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         p1_ff <= p1_in;
         v1_ff <= in_value;
      end
      if (ready[1]) begin
         p2_ff <= p1_ff;
         t2_2_ff <= t2_2_in;
         v2_ff <= v1_ff;
      end
      if (ready[2]) begin
         p3_ff <= p2_ff;
         t2_3_ff <= t2_2_ff;
         t3_3_ff <= t3_3_in;
         v3_ff <= v2_ff;
      end
      if (ready[3]) begin
         w4_ff <= w4_in;
         v4_ff <= v3_ff;
      end
   end

endmodule

/* src/chev_mac.sv */
module chev_mac #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [chev_pkg::SUM_COUNT-1:0][chev_pkg::TERM_COUNT-1:0][FRAC_BITS+3:0] in_weight,
   input  logic [chev_pkg::TERM_COUNT-1:0][COORD_WIDTH-1:0] in_value,
   output logic out_valid,
   input  logic out_ready,
   output logic [COORD_WIDTH-1:0] out_position,
   output logic [COORD_WIDTH-1:0] out_slope,
   output logic out_saturated
);
   import chev_pkg::*;

   localparam int WW = FRAC_BITS + 4;
   localparam int LW = COORD_WIDTH / 2;            // low half, unsigned
   localparam int HW = COORD_WIDTH - LW;           // high half, signed
   localparam int PHW = WW + HW;
   localparam int PLW = WW + LW + 1;
   localparam int TW = WW + COORD_WIDTH;
   localparam int SW = TW + 2;
   localparam int STAGES = 3;
   localparam logic signed [SW-1:0] ROUND = SW'(1) << (FRAC_BITS - 1);
   localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] ready;

   logic signed [PHW-1:0] ph_ff [SUM_COUNT][TERM_COUNT];
   logic signed [PHW-1:0] ph_in [SUM_COUNT][TERM_COUNT];
   logic signed [PLW-1:0] pl_ff [SUM_COUNT][TERM_COUNT];
   logic signed [PLW-1:0] pl_in [SUM_COUNT][TERM_COUNT];
   logic signed [TW-1:0] term_ff [SUM_COUNT][TERM_COUNT];
   logic signed [TW-1:0] term_in [SUM_COUNT][TERM_COUNT];
   logic signed [SW-1:0] acc [SUM_COUNT];
   logic signed [SW-1:0] quo [SUM_COUNT];
   logic [SUM_COUNT-1:0] clip;
   logic [SUM_COUNT-1:0][COORD_WIDTH-1:0] res_in;
   logic [SUM_COUNT-1:0][COORD_WIDTH-1:0] res_ff;
   logic sat_ff;

   always_comb begin
      ready[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign in_ready = ready[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_position = res_ff[POSITION_SEL];
   assign out_slope = res_ff[SLOPE_SEL];
   assign out_saturated = sat_ff;

   // values split in halves so each product stays a modest multiplier
   always_comb begin
      for (int k = 0; k < SUM_COUNT; k++) begin
         for (int i = 0; i < TERM_COUNT; i++) begin
            ph_in[k][i] = $signed(in_weight[k][i]) * $signed(in_value[i][COORD_WIDTH-1:LW]);
            pl_in[k][i] = $signed(in_weight[k][i]) * $signed({1'b0, in_value[i][LW-1:0]});
            term_in[k][i] = $signed({ph_ff[k][i], {LW{1'b0}}})
                          + $signed({{(TW-PLW){pl_ff[k][i][PLW-1]}}, pl_ff[k][i]});
         end
      end
   end

   // exact sum, round half up, then clip to the coordinate range
   always_comb begin
      for (int k = 0; k < SUM_COUNT; k++) begin
         acc[k] = ROUND;
         for (int i = 0; i < TERM_COUNT; i++) begin
            acc[k] = acc[k] + $signed({{(SW-TW){term_ff[k][i][TW-1]}}, term_ff[k][i]});
         end
         quo[k] = acc[k] >>> FRAC_BITS;
         clip[k] = !((&quo[k][SW-1:COORD_WIDTH-1]) || !(|quo[k][SW-1:COORD_WIDTH-1]));
         if (!clip[k]) begin
            res_in[k] = quo[k][COORD_WIDTH-1:0];
         end else if (quo[k][SW-1]) begin
            res_in[k] = CMIN;
         end else begin
            res_in[k] = CMAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int i = 1; i < STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
      if (ready[1]) begin
         term_ff <= term_in;
      end
      if (ready[2]) begin
         res_ff <= res_in;
         sat_ff <= |clip;
      end
   end

endmodule

/* src/cubic_hermite_evaluator_core.sv */
// Cubic Hermite evaluator: position and slope of one coordinate per transfer.
// Pipeline: 4 basis stages, then 3 MAC stages, from req transfer to rsp_tvalid.
// Throughput: one item per cycle unless the rsp side stalls; a stalled rsp side holds only the stages behind it,
// empty stages keep filling, so bubbles are squeezed out.
// Reset: synchronous, active high; clears the stage valid bits only.
module cubic_hermite_evaluator_core #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // param, start_point, end_point, start_tangent, end_tangent
   input  logic [((FRAC_BITS + 4 * COORD_WIDTH + 8) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // position, slope
   output logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // saturated
   output logic [0:0] rsp_tuser
);
   import chev_pkg::*;

   localparam int PW = FRAC_BITS + 1;
   localparam int WW = FRAC_BITS + 4;
   localparam int RSP_DW = ((2 * COORD_WIDTH + 7) / 8) * 8;

   logic [PW-1:0] req_param;
   logic [TERM_COUNT-1:0][COORD_WIDTH-1:0] req_value;
   logic mid_valid;
   logic mid_ready;
   logic [SUM_COUNT-1:0][TERM_COUNT-1:0][WW-1:0] mid_weight;
   logic [TERM_COUNT-1:0][COORD_WIDTH-1:0] mid_value;
   logic [COORD_WIDTH-1:0] rsp_position;
   logic [COORD_WIDTH-1:0] rsp_slope;
   logic rsp_saturated;

   always_comb begin
      req_param = req_tdata[PW-1:0];
      for (int i = 0; i < TERM_COUNT; i++) begin
         req_value[i] = req_tdata[PW + i * COORD_WIDTH +: COORD_WIDTH];
      end
   end

   chev_basis #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_basis (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_param(req_param),
      .in_value(req_value),
      .out_valid(mid_valid),
      .out_ready(mid_ready),
      .out_weight(mid_weight),
      .out_value(mid_value)
   );

   chev_mac #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_mac (
      .clock(clock),
      .reset(reset),
      .in_valid(mid_valid),
      .in_ready(mid_ready),
      .in_weight(mid_weight),
      .in_value(mid_value),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_position(rsp_position),
      .out_slope(rsp_slope),
      .out_saturated(rsp_saturated)
   );

   assign rsp_tdata = RSP_DW'({rsp_slope, rsp_position});
   assign rsp_tuser = rsp_saturated;

endmodule

/* src/chev_checker.sv */
module chev_checker #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic [0:0] rsp_tuser
);

   // pipeline must come out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid set straight after reset");

   // an empty or draining output never backs up the input side
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("req_tready low while output side can move");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

endmodule

bind cubic_hermite_evaluator_core chev_checker #(
   .COORD_WIDTH(COORD_WIDTH),
   .FRAC_BITS(FRAC_BITS)
) u_chev_checker (.*);

/* test/tb_cubic_hermite_evaluator_core.sv */
`timescale 1ns / 1ps

module tb_cubic_hermite_evaluator_core;
   import chev_pkg::*;

   localparam int COORD_W = 32;
   localparam int FRAC = 16;
   localparam int PARAM_W = FRAC + 1;
   localparam int REQ_W = ((FRAC + 4 * COORD_W + 8) / 8) * 8;
   localparam int RSP_W = ((2 * COORD_W + 7) / 8) * 8;
   localparam longint UNIT = longint'(1) << FRAC;
   localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
   localparam longint COORD_LO = -(longint'(1) << (COORD_W - 1));
   localparam logic [COORD_W-1:0] C_MAX = COORD_HI[COORD_W-1:0];
   localparam logic [COORD_W-1:0] C_MIN = COORD_LO[COORD_W-1:0];
   localparam int ITEMS_PER_MODE = 425;

   typedef enum int {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_RECEIVER_STALLS, FLOW_BOTH} flow_mode_type;

   typedef struct {
      logic [PARAM_W-1:0] param;
      logic signed [COORD_W-1:0] start_point;
      logic signed [COORD_W-1:0] end_point;
      logic signed [COORD_W-1:0] start_tangent;
      logic signed [COORD_W-1:0] end_tangent;
   } hermite_segment_type;

   typedef struct {
      logic [COORD_W-1:0] position;
      logic [COORD_W-1:0] slope;
      logic saturated;
   } hermite_result_type;

   class hermite_checker;
      hermite_result_type pending[$];
      int mismatches;
      int checked;
      int clipped;

      function new();
         mismatches = 0;
         checked = 0;
         clipped = 0;
      endfunction

      task flag_mismatch(input string what);
         $display("%0t ns mismatch: %s", $time, what);
         mismatches++;
      endtask

      // clip to the coordinate range, returns 1 when clipped
      function bit clip_coord(input longint x, output logic [COORD_W-1:0] y);
         if (x > COORD_HI) begin
            y = C_MAX;
            return 1'b1;
         end
         if (x < COORD_LO) begin
            y = C_MIN;
            return 1'b1;
         end
         y = x[COORD_W-1:0];
         return 1'b0;
      endfunction

      function hermite_result_type evaluate_segment(input hermite_segment_type s);
         longint p, t2, t3, pos_sum, slope_sum;
         longint coord[TERM_COUNT];
         longint shape[TERM_COUNT];
         longint bend[TERM_COUNT];
         bit hit_pos, hit_slope;
         hermite_result_type r;
         p = (longint'(s.param) > UNIT) ? UNIT : longint'(s.param);
         t2 = (p * p + UNIT / 2) >>> FRAC;
         t3 = (t2 * p + UNIT / 2) >>> FRAC;
         coord[START_POINT_IDX] = longint'(s.start_point);
         coord[END_POINT_IDX] = longint'(s.end_point);
         coord[START_TANGENT_IDX] = longint'(s.start_tangent);
         coord[END_TANGENT_IDX] = longint'(s.end_tangent);
         shape[START_POINT_IDX] = 2 * t3 - 3 * t2 + UNIT;
         shape[END_POINT_IDX] = 3 * t2 - 2 * t3;
         shape[START_TANGENT_IDX] = t3 - 2 * t2 + p;
         shape[END_TANGENT_IDX] = t3 - t2;
         bend[START_POINT_IDX] = 6 * t2 - 6 * p;
         bend[END_POINT_IDX] = 6 * p - 6 * t2;
         bend[START_TANGENT_IDX] = 3 * t2 - 4 * p + UNIT;
         bend[END_TANGENT_IDX] = 3 * t2 - 2 * p;
         pos_sum = 0;
         slope_sum = 0;
         for (int i = 0; i < TERM_COUNT; i++) begin
            pos_sum += shape[i] * coord[i];
            slope_sum += bend[i] * coord[i];
         end
         // round half up: arithmetic shift floors
         hit_pos = clip_coord((pos_sum + UNIT / 2) >>> FRAC, r.position);
         hit_slope = clip_coord((slope_sum + UNIT / 2) >>> FRAC, r.slope);
         r.saturated = hit_pos | hit_slope;
         return r;
      endfunction

      function void note_segment(input hermite_segment_type s);
         hermite_result_type r;
         r = evaluate_segment(s);
         if (r.saturated)
            clipped++;
         pending.push_back(r);
      endfunction

      task check_result(input logic [COORD_W-1:0] position, input logic [COORD_W-1:0] slope,
                        input logic saturated);
         hermite_result_type want;
         if (pending.size() == 0) begin
            flag_mismatch($sformatf("result %h/%h with nothing pending", position, slope));
         end else begin
            want = pending.pop_front();
            checked++;
            if (position !== want.position)
               flag_mismatch($sformatf("position got %h want %h", position, want.position));
            if (slope !== want.slope)
               flag_mismatch($sformatf("slope got %h want %h", slope, want.slope));
            if (saturated !== want.saturated)
               flag_mismatch($sformatf("saturated got %b want %b", saturated, want.saturated));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   flow_mode_type flow_mode;
   int accepted = 0;
   hermite_checker ledger = new();

   cubic_hermite_evaluator_core #(
      .COORD_WIDTH(COORD_W),
      .FRAC_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int gap_percent(input bit for_receiver);
      case (flow_mode)
         FLOW_SENDER_GAPS: return for_receiver ? 0 : 87;
         FLOW_RECEIVER_STALLS: return for_receiver ? 87 : 0;
         FLOW_BOTH: return 16;
         default: return 0;
      endcase
   endfunction

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= gap_percent(1'b1));
   end

   function automatic hermite_segment_type make_segment(input logic [PARAM_W-1:0] p,
                                                        input logic [COORD_W-1:0] p0,
                                                        input logic [COORD_W-1:0] p1,
                                                        input logic [COORD_W-1:0] m0,
                                                        input logic [COORD_W-1:0] m1);
      hermite_segment_type s;
      s.param = p;
      s.start_point = p0;
      s.end_point = p1;
      s.start_tangent = m0;
      s.end_tangent = m1;
      return s;
   endfunction

   function automatic hermite_segment_type unpack_segment(input logic [REQ_W-1:0] d);
      return make_segment(d[PARAM_W-1:0], d[PARAM_W +: COORD_W],
                          d[PARAM_W + COORD_W +: COORD_W],
                          d[PARAM_W + 2 * COORD_W +: COORD_W],
                          d[PARAM_W + 3 * COORD_W +: COORD_W]);
   endfunction

   // inputs sampled before the edge's updates, so note and check order is fixed here
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            ledger.note_segment(unpack_segment(req_tdata));
            accepted++;
         end
         if (rsp_tvalid && rsp_tready)
            ledger.check_result(rsp_tdata[COORD_W-1:0], rsp_tdata[2*COORD_W-1:COORD_W],
                                rsp_tuser[0]);
      end
   end

   task automatic send_segment(input hermite_segment_type s);
      @(negedge clock);
      while ($urandom_range(99) < gap_percent(1'b0)) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({s.end_tangent, s.start_tangent, s.end_point, s.start_point,
                           s.param});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // a good share of small magnitudes so that plenty of results stay in range
   function automatic logic [COORD_W-1:0] random_coord();
      case ($urandom_range(9))
         0: return C_MAX;
         1: return C_MIN;
         2, 3, 4: return $urandom();
         5: return int'($urandom()) >>> 6;
         default: return int'($urandom_range(2097151)) - 1048576;
      endcase
   endfunction

   function automatic logic [PARAM_W-1:0] random_param();
      case ($urandom_range(19))
         0: return '0;
         1: return UNIT[PARAM_W-1:0];
         2: return PARAM_W'($urandom_range(2 ** PARAM_W - 1, UNIT + 1));
         default: return PARAM_W'($urandom_range(UNIT));
      endcase
   endfunction

   function automatic hermite_segment_type random_segment();
      return make_segment(random_param(), random_coord(), random_coord(), random_coord(),
                          random_coord());
   endfunction

   initial begin
      hermite_segment_type directed[$];
      flow_mode_type modes[4];
      int drain;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      flow_mode = FLOW_FREE;
      modes = '{FLOW_FREE, FLOW_SENDER_GAPS, FLOW_RECEIVER_STALLS, FLOW_BOTH};
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      directed.push_back(make_segment('0, 0, 0, 0, 0));
      directed.push_back(make_segment('0, C_MAX, $urandom(), $urandom(), $urandom()));
      directed.push_back(make_segment(UNIT[PARAM_W-1:0], $urandom(), C_MIN, $urandom(),
                                      $urandom()));
      directed.push_back(make_segment(PARAM_W'(UNIT / 2), C_MAX, C_MAX, C_MAX, C_MAX));
      // position clips high, then low
      directed.push_back(make_segment(PARAM_W'(UNIT / 2), C_MAX, C_MAX, C_MAX, C_MIN));
      directed.push_back(make_segment(PARAM_W'(UNIT / 2), C_MIN, C_MIN, C_MIN, C_MAX));
      // slope clips high, then low
      directed.push_back(make_segment(PARAM_W'(UNIT / 2), C_MIN, C_MAX, 0, 0));
      directed.push_back(make_segment(PARAM_W'(UNIT / 2), C_MAX, C_MIN, 0, 0));
      // parameter beyond one is held at one
      directed.push_back(make_segment('1, $urandom(), $urandom(), $urandom(), $urandom()));
      directed.push_back(make_segment(PARAM_W'(UNIT + 1), $urandom(), $urandom(), 0, 0));
      directed.push_back(make_segment('1, '1, '1, '1, '1));
      directed.push_back(make_segment(PARAM_W'(1), C_MIN, C_MAX, C_MIN, C_MAX));
      directed.push_back(make_segment(PARAM_W'(UNIT - 1), C_MAX, C_MIN, C_MAX, C_MIN));
      directed.push_back(make_segment(17'h0AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                                      32'hAAAA_AAAA, 32'h5555_5555));
      directed.push_back(make_segment(17'h15555, 32'h5555_5555, 32'hAAAA_AAAA,
                                      32'h5555_5555, 32'hAAAA_AAAA));
      // unit default tangents
      directed.push_back(make_segment(PARAM_W'(UNIT / 4), 32'h0002_0000, 32'h0005_0000,
                                      32'h0001_0000, 32'h0001_0000));
      directed.push_back(make_segment(PARAM_W'(3 * UNIT / 4), 32'hFFFF_0000, 32'h0000_8000,
                                      32'h0001_0000, 32'h0001_0000));
      repeat (3) directed.push_back(random_segment());

      foreach (directed[i])
         send_segment(directed[i]);

      foreach (modes[m]) begin
         flow_mode = modes[m];
         repeat (ITEMS_PER_MODE)
            send_segment(random_segment());
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      flow_mode = FLOW_FREE;
      while (ledger.pending.size() != 0)
         @(posedge clock);
      // catch anything spurious behind the last result
      drain = 20;
      repeat (drain) @(posedge clock);

      $display("%0d segments sent, %0d results checked, %0d of them clipped",
               accepted, ledger.checked, ledger.clipped);
      $display("idle patterns: free flow, sender gaps, receiver stalls, both; %0d mismatches",
               ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", ledger.pending.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
